// File: rtl/core/fstge_pkg.sv
// ----------------------------------------------------------------------------
// fstge_pkg
// Shared types, codes and level functions for the ten-valued gate evaluator.
// ----------------------------------------------------------------------------
package fstge_pkg;

  // Ten-value signal codes: steady levels, then old-to-new transitions
  localparam logic [3:0] CODE_O  = 4'd0;
  localparam logic [3:0] CODE_I  = 4'd1;
  localparam logic [3:0] CODE_X  = 4'd2;
  localparam logic [3:0] CODE_Z  = 4'd3;
  localparam logic [3:0] CODE_OI = 4'd4;
  localparam logic [3:0] CODE_IO = 4'd5;
  localparam logic [3:0] CODE_OX = 4'd6;
  localparam logic [3:0] CODE_XO = 4'd7;
  localparam logic [3:0] CODE_IX = 4'd8;
  localparam logic [3:0] CODE_XI = 4'd9;

  typedef enum logic [2:0] {
    CMD_AND  = 3'd0,
    CMD_OR   = 3'd1,
    CMD_NAND = 3'd2,
    CMD_NOR  = 3'd3,
    CMD_XOR  = 3'd4,
    CMD_XNOR = 3'd5,
    CMD_NOT  = 3'd6,
    CMD_BUF  = 3'd7
  } cmd_t;

  // Per-phase logic level
  typedef enum logic [1:0] {
    LV_O = 2'd0,
    LV_I = 2'd1,
    LV_X = 2'd2
  } lv_t;

  typedef lv_t [3:0] lv_quad_t;

  typedef struct packed {
    logic [2:0] command;
    logic [3:0] in_a;
    logic [3:0] in_b;
    logic [3:0] in_c;
    logic [3:0] in_d;
  } in_beat_t;

  typedef struct packed {
    logic [3:0] value_out;
  } out_beat_t;

  // Level before the transition; Z and undefined codes read as X
  function automatic lv_t old_level(input logic [3:0] code);
    lv_t r;
    unique case (code)
      CODE_O, CODE_OI, CODE_OX: r = LV_O;
      CODE_I, CODE_IO, CODE_IX: r = LV_I;
      default:                  r = LV_X;
    endcase
    return r;
  endfunction

  // Level after the transition
  function automatic lv_t new_level(input logic [3:0] code);
    lv_t r;
    unique case (code)
      CODE_O, CODE_IO, CODE_XO: r = LV_O;
      CODE_I, CODE_OI, CODE_XI: r = LV_I;
      default:                  r = LV_X;
    endcase
    return r;
  endfunction

  // Rebuild a ten-value code from the two phase levels
  function automatic logic [3:0] join_code(input lv_t po, input lv_t pn);
    logic [3:0] r;
    unique case ({po, pn})
      {LV_O, LV_O}: r = CODE_O;
      {LV_O, LV_I}: r = CODE_OI;
      {LV_O, LV_X}: r = CODE_OX;
      {LV_I, LV_O}: r = CODE_IO;
      {LV_I, LV_I}: r = CODE_I;
      {LV_I, LV_X}: r = CODE_IX;
      {LV_X, LV_O}: r = CODE_XO;
      {LV_X, LV_I}: r = CODE_XI;
      default:      r = CODE_X;
    endcase
    return r;
  endfunction

  function automatic lv_t lv_and(input lv_t a, input lv_t b);
    lv_t r;
    if (a == LV_O || b == LV_O) begin
      r = LV_O;
    end else if (a == LV_I && b == LV_I) begin
      r = LV_I;
    end else begin
      r = LV_X;
    end
    return r;
  endfunction

  function automatic lv_t lv_or(input lv_t a, input lv_t b);
    lv_t r;
    if (a == LV_I || b == LV_I) begin
      r = LV_I;
    end else if (a == LV_O && b == LV_O) begin
      r = LV_O;
    end else begin
      r = LV_X;
    end
    return r;
  endfunction

  function automatic lv_t lv_xor(input lv_t a, input lv_t b);
    lv_t r;
    if ((a == LV_O || a == LV_I) && (b == LV_O || b == LV_I)) begin
      r = (a == b) ? LV_O : LV_I;
    end else begin
      r = LV_X;
    end
    return r;
  endfunction

  function automatic lv_t lv_not(input lv_t a);
    lv_t r;
    unique case (a)
      LV_O:    r = LV_I;
      LV_I:    r = LV_O;
      default: r = LV_X;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/fstge_if.sv
// ----------------------------------------------------------------------------
// fstge_if
// Valid/ready channels carrying gate beats into and results out of the block.
// ----------------------------------------------------------------------------
interface fstge_in_if;
  import fstge_pkg::*;

  logic     valid;
  logic     ready;
  in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface fstge_out_if;
  import fstge_pkg::*;

  logic      valid;
  logic      ready;
  out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/fstge_phase.sv
// ----------------------------------------------------------------------------
// fstge_phase
// Evaluates the selected gate over four single-phase levels; NOT reads only the first.
// ----------------------------------------------------------------------------
module fstge_phase (
  input  fstge_pkg::cmd_t     command,
  input  fstge_pkg::lv_quad_t lv,
  output fstge_pkg::lv_t      result
);
  import fstge_pkg::*;

  lv_t and_r;
  lv_t or_r;
  lv_t xor_r;

  assign and_r = lv_and(lv_and(lv_and(lv[0], lv[1]), lv[2]), lv[3]);
  assign or_r  = lv_or(lv_or(lv_or(lv[0], lv[1]), lv[2]), lv[3]);
  assign xor_r = lv_xor(lv_xor(lv_xor(lv[0], lv[1]), lv[2]), lv[3]);

  always_comb begin
    unique case (command)
      CMD_AND:  result = and_r;
      CMD_NAND: result = lv_not(and_r);
      CMD_OR:   result = or_r;
      CMD_NOR:  result = lv_not(or_r);
      CMD_XOR:  result = xor_r;
      CMD_XNOR: result = lv_not(xor_r);
      // buffer is resolved on the full code at the top level
      default:  result = lv_not(lv[0]);
    endcase
  end

endmodule

// File: rtl/core/four_state_transition_gate_eval.sv
// ----------------------------------------------------------------------------
// four_state_transition_gate_eval
// Ten-valued gate evaluator: AND/OR/XOR and inversions over four inputs,
// NOT and BUF over the first, with transitions split into old/new phases.
// ----------------------------------------------------------------------------
// Usage:
//   gate_in  carries one gate per beat: command plus four ten-value codes.
//   gate_out carries one ten-value result per beat, in input order.
//   Each beat is captured in an input register, evaluated by one pass of
//   short logic (two phase evaluators and a join), and held in a result
//   register. Throughput is one beat per cycle: both registers advance
//   together whenever the result register is empty or being drained.
//   If the receiver stalls, the result register and the input register
//   each hold one beat, then gate_in.ready drops until gate_out drains.
//   A synchronous reset empties both registers; no beat is lost after it.
// ----------------------------------------------------------------------------
module four_state_transition_gate_eval (
  input  logic               clk,
  input  logic               rst,
  fstge_in_if.sink           gate_in,
  fstge_out_if.source        gate_out
);
  import fstge_pkg::*;

  logic      s1_valid;
  in_beat_t  s1_beat;
  logic      out_valid;
  out_beat_t out_beat;
  logic      out_adv;
  logic      s1_adv;

  lv_quad_t   lv_old;
  lv_quad_t   lv_new;
  lv_t        po;
  lv_t        pn;
  cmd_t       cmd;
  logic [3:0] value_next;

  // Advance when the next register is free or emptying this cycle
  assign out_adv       = !out_valid || gate_out.ready;
  assign s1_adv        = !s1_valid || out_adv;
  assign gate_in.ready = s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv) begin
      s1_valid <= gate_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && gate_in.valid) begin
      s1_beat <= gate_in.data;
    end
  end

  assign cmd = cmd_t'(s1_beat.command);

  always_comb begin
    lv_old[0] = old_level(s1_beat.in_a);
    lv_old[1] = old_level(s1_beat.in_b);
    lv_old[2] = old_level(s1_beat.in_c);
    lv_old[3] = old_level(s1_beat.in_d);
    lv_new[0] = new_level(s1_beat.in_a);
    lv_new[1] = new_level(s1_beat.in_b);
    lv_new[2] = new_level(s1_beat.in_c);
    lv_new[3] = new_level(s1_beat.in_d);
  end

  fstge_phase u_phase_old (
    .command (cmd),
    .lv      (lv_old),
    .result  (po)
  );

  fstge_phase u_phase_new (
    .command (cmd),
    .lv      (lv_new),
    .result  (pn)
  );

  // Buffer passes valid codes through, turning Z and undefined codes into X
  always_comb begin
    if (cmd == CMD_BUF) begin
      if (s1_beat.in_a == CODE_Z || s1_beat.in_a > CODE_XI) begin
        value_next = CODE_X;
      end else begin
        value_next = s1_beat.in_a;
      end
    end else begin
      value_next = join_code(po, pn);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid) begin
      out_beat.value_out <= value_next;
    end
  end

  assign gate_out.valid = out_valid;
  assign gate_out.data  = out_beat;

endmodule

// File: sim/gate_result_checker.sv
// ----------------------------------------------------------------------------
// gate_result_checker
// Watches the gate and result channels of the ten-valued gate evaluator.
// Predicts each gate output from the accepted beat and compares it, in
// order, with the beats that leave the block.
// ----------------------------------------------------------------------------
module gate_result_checker (
  input  logic  clk,
  input  logic  rst,
  fstge_in_if   gate_in,
  fstge_out_if  gate_out,
  output int    fail_count,
  output int    outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import fstge_pkg::*;

  logic [3:0] results_due[$];

  // Level before the transition; Z and unused codes read as X
  function automatic lv_t level_before(input logic [3:0] code);
    lv_t r;
    case (code)
      CODE_O, CODE_OI, CODE_OX: r = LV_O;
      CODE_I, CODE_IO, CODE_IX: r = LV_I;
      default:                  r = LV_X;
    endcase
    return r;
  endfunction

  // Level after the transition
  function automatic lv_t level_after(input logic [3:0] code);
    lv_t r;
    case (code)
      CODE_O, CODE_IO, CODE_XO: r = LV_O;
      CODE_I, CODE_OI, CODE_XI: r = LV_I;
      default:                  r = LV_X;
    endcase
    return r;
  endfunction

  // Evaluate the gate on one phase of all four inputs; NOT reads only the first
  function automatic lv_t gate_phase(input cmd_t op, input lv_t l0, input lv_t l1,
                                     input lv_t l2, input lv_t l3);
    lv_t lv[4];
    lv_t r;
    logic any_o;
    logic any_i;
    logic any_x;
    logic parity;
    lv[0] = l0;
    lv[1] = l1;
    lv[2] = l2;
    lv[3] = l3;
    any_o  = 1'b0;
    any_i  = 1'b0;
    any_x  = 1'b0;
    parity = 1'b0;
    for (int k = 0; k < 4; k++) begin
      any_o  |= (lv[k] == LV_O);
      any_i  |= (lv[k] == LV_I);
      any_x  |= (lv[k] == LV_X);
      parity ^= (lv[k] == LV_I);
    end
    case (op)
      CMD_AND, CMD_NAND: r = any_o ? LV_O : (any_x ? LV_X : LV_I);
      CMD_OR, CMD_NOR:   r = any_i ? LV_I : (any_x ? LV_X : LV_O);
      CMD_XOR, CMD_XNOR: r = any_x ? LV_X : (parity ? LV_I : LV_O);
      default:           r = lv[0];
    endcase
    // invert for the negated gates and NOT; X stays X
    if (op == CMD_NAND || op == CMD_NOR || op == CMD_XNOR || op == CMD_NOT) begin
      if (r == LV_O) begin
        r = LV_I;
      end else if (r == LV_I) begin
        r = LV_O;
      end
    end
    return r;
  endfunction

  // Merge old and new phase levels back into one ten-value code
  function automatic logic [3:0] merge_phases(input lv_t po, input lv_t pn);
    logic [3:0] r;
    if (po == pn) begin
      r = (po == LV_O) ? CODE_O : (po == LV_I) ? CODE_I : CODE_X;
    end else begin
      case (po)
        LV_O:    r = (pn == LV_I) ? CODE_OI : CODE_OX;
        LV_I:    r = (pn == LV_O) ? CODE_IO : CODE_IX;
        default: r = (pn == LV_O) ? CODE_XO : CODE_XI;
      endcase
    end
    return r;
  endfunction

  function automatic logic [3:0] gate_output(input in_beat_t b);
    cmd_t op;
    lv_t  po;
    lv_t  pn;
    logic [3:0] r;
    op = cmd_t'(b.command);
    if (op == CMD_BUF) begin
      r = (b.in_a == CODE_Z || b.in_a > CODE_XI) ? CODE_X : b.in_a;
    end else begin
      po = gate_phase(op, level_before(b.in_a), level_before(b.in_b),
                      level_before(b.in_c), level_before(b.in_d));
      pn = gate_phase(op, level_after(b.in_a), level_after(b.in_b),
                      level_after(b.in_c), level_after(b.in_d));
      r = merge_phases(po, pn);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    logic [3:0] want;
    if (!rst) begin
      if (gate_out.valid && gate_out.ready) begin
        if (results_due.size() == 0) begin
          $error("value_out: unexpected beat, got %0d", gate_out.data.value_out);
          fail_count = fail_count + 1;
        end else begin
          want = results_due.pop_front();
          if (gate_out.data.value_out !== want) begin
            $error("value_out mismatch: expected %0d, got %0d",
                   want, gate_out.data.value_out);
            fail_count = fail_count + 1;
          end
        end
      end
      if (gate_in.valid && gate_in.ready) begin
        results_due.push_back(gate_output(gate_in.data));
      end
    end
    outstanding = results_due.size();
  end

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives gate beats into the ten-valued gate evaluator with random gaps and
// random result back-pressure: a directed set of corner cases first, then
// random gates. The checker predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fstge_pkg::*;

  localparam int         RANDOM_GATES = 1150;
  localparam int         CYCLE_LIMIT  = 200000;
  localparam int         DRAIN_CYCLES = 10;
  // codes ten to fifteen are unused by the encoding and read as X
  localparam logic [3:0] UNUSED_LO    = 4'd10;
  localparam logic [3:0] UNUSED_MID   = 4'd13;
  localparam logic [3:0] UNUSED_HI    = 4'd15;

  logic clk;
  logic rst;
  int   fail_count;
  int   outstanding;
  int   cycles;
  int   sent;
  int   drained;

  fstge_in_if  gate_in ();
  fstge_out_if gate_out ();

  four_state_transition_gate_eval dut (
    .clk      (clk),
    .rst      (rst),
    .gate_in  (gate_in),
    .gate_out (gate_out)
  );

  gate_result_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .gate_in     (gate_in),
    .gate_out    (gate_out),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Offer one gate beat after a random gap; return at the falling edge after accept
  task automatic send_gate(input cmd_t op, input logic [3:0] a, input logic [3:0] b,
                           input logic [3:0] c, input logic [3:0] d);
    in_beat_t beat;
    int gap;
    beat.command = op;
    beat.in_a = a;
    beat.in_b = b;
    beat.in_c = c;
    beat.in_d = d;
    gap = (sent % 200 < 40) ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      gate_in.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    gate_in.valid <= 1'b1;
    gate_in.data  <= beat;
    @(posedge clk);
    while (!gate_in.ready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  function automatic logic [3:0] random_code();
    logic [3:0] r;
    if ($urandom_range(0, 7) == 0) begin
      r = 4'($urandom_range(UNUSED_LO, UNUSED_HI));
    end else begin
      r = 4'($urandom_range(CODE_O, CODE_XI));
    end
    return r;
  endfunction

  // Draw from codes that do not force the AND/OR families, so deeper cases show up
  function automatic logic [3:0] passive_code(input cmd_t op);
    logic [3:0] r;
    int pick;
    pick = $urandom_range(0, 4);
    if (op == CMD_AND || op == CMD_NAND) begin
      case (pick)
        0: r = CODE_I;
        1: r = CODE_XI;
        2: r = CODE_IX;
        3: r = CODE_Z;
        default: r = CODE_I;
      endcase
    end else begin
      case (pick)
        0: r = CODE_O;
        1: r = CODE_XO;
        2: r = CODE_OX;
        3: r = CODE_Z;
        default: r = CODE_O;
      endcase
    end
    return r;
  endfunction

  // Receiver: stall a random number of cycles before taking each result
  initial begin
    int stall;
    gate_out.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    drained = 0;
    forever begin
      stall = (drained % 150 < 30) ? 0 : $urandom_range(0, 9);
      repeat (stall) begin
        gate_out.ready <= 1'b0;
        @(negedge clk);
      end
      gate_out.ready <= 1'b1;
      @(posedge clk);
      while (!gate_out.valid) @(posedge clk);
      drained++;
      @(negedge clk);
    end
  end

  initial begin
    cmd_t op;
    logic [3:0] a, b, c, d;
    rst = 1'b1;
    sent = 0;
    gate_in.valid = 1'b0;
    gate_in.data  = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed corners
    send_gate(CMD_AND,  CODE_I,    CODE_I,  CODE_I,    CODE_I);
    send_gate(CMD_AND,  CODE_OI,   CODE_I,  CODE_I,    CODE_XI);
    send_gate(CMD_AND,  CODE_Z,    CODE_I,  CODE_I,    CODE_I);
    send_gate(CMD_AND,  UNUSED_HI, CODE_O,  CODE_I,    CODE_I);
    send_gate(CMD_OR,   CODE_O,    CODE_O,  CODE_O,    CODE_O);
    send_gate(CMD_OR,   CODE_IO,   CODE_O,  CODE_OX,   CODE_O);
    send_gate(CMD_NAND, CODE_OI,   CODE_OI, CODE_OI,   CODE_OI);
    send_gate(CMD_NOR,  CODE_XO,   CODE_O,  CODE_O,    CODE_Z);
    send_gate(CMD_XOR,  CODE_OI,   CODE_IO, CODE_I,    CODE_O);
    send_gate(CMD_XOR,  CODE_Z,    CODE_O,  CODE_O,    CODE_O);
    send_gate(CMD_XNOR, CODE_IX,   CODE_XI, CODE_O,    CODE_I);
    send_gate(CMD_XNOR, UNUSED_LO, CODE_O,  CODE_O,    CODE_O);
    send_gate(CMD_NOT,  CODE_Z,    CODE_O,  CODE_O,    CODE_O);
    send_gate(CMD_NOT,  CODE_OX,   CODE_I,  CODE_I,    CODE_I);
    send_gate(CMD_NOT,  UNUSED_LO, CODE_O,  CODE_O,    CODE_O);
    send_gate(CMD_NOT,  CODE_IO,   UNUSED_HI, UNUSED_HI, UNUSED_HI);
    send_gate(CMD_BUF,  CODE_Z,    CODE_O,  CODE_O,    CODE_O);
    send_gate(CMD_BUF,  CODE_XI,   CODE_X,  CODE_X,    CODE_X);
    send_gate(CMD_BUF,  UNUSED_MID, CODE_O, CODE_O,    CODE_O);
    send_gate(CMD_BUF,  UNUSED_HI, CODE_O,  CODE_O,    CODE_O);
    send_gate(CMD_BUF,  CODE_O,    CODE_XI, CODE_XI,   CODE_XI);
    send_gate(CMD_XOR,  CODE_XI,   CODE_XI, CODE_XI,   CODE_XI);

    // hold off until the block has drained
    gate_in.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);

    for (int n = 0; n < RANDOM_GATES; n++) begin
      op = cmd_t'(3'($urandom_range(0, 7)));
      if ($urandom_range(0, 1) == 0) begin
        a = random_code();
        b = random_code();
        c = random_code();
        d = random_code();
      end else begin
        a = passive_code(op);
        b = passive_code(op);
        c = passive_code(op);
        d = random_code();
      end
      send_gate(op, a, b, c, d);
      if (n == RANDOM_GATES / 2) begin
        gate_in.valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
      end
    end

    gate_in.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
